@@ src/tcx_pkg.sv @@
// tcx_pkg: shared constants, opcode and error codes, FSM states and
// stack port structs for the toy CPU execute unit.
// No dependencies; used by every module under src except tcx_ram.
package tcx_pkg;

	// Stack store size in bytes. Addresses wrap by masking, so keep it a power of two.
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int BANK_AW   = ADDR_W - 1;
	localparam int BANK_DEPTH = MEM_BYTES / 2;
	localparam int DATA_W    = 16;

	typedef enum logic [4:0] {
		CMD_NOP  = 5'd0,
		CMD_HLT  = 5'd1,
		CMD_MOVA = 5'd2,
		CMD_MOVB = 5'd3,
		CMD_MOVC = 5'd4,
		CMD_MOVD = 5'd5,
		CMD_MOVS = 5'd6,
		CMD_ADD  = 5'd7,
		CMD_SUB  = 5'd8,
		CMD_MUL  = 5'd9,
		CMD_DIV  = 5'd10,
		CMD_STE  = 5'd11,
		CMD_CLE  = 5'd12,
		CMD_STG  = 5'd13,
		CMD_CLG  = 5'd14,
		CMD_STH  = 5'd15,
		CMD_CLH  = 5'd16,
		CMD_STL  = 5'd17,
		CMD_CLL  = 5'd18,
		CMD_PUSH = 5'd19,
		CMD_POP  = 5'd20
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_DIV0    = 3'd1,
		ERR_OVER    = 3'd2,
		ERR_UNDER   = 3'd3,
		ERR_BADREG  = 3'd4,
		ERR_ILLEGAL = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_POP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} stk_req_t;

	typedef struct packed {
		logic              clr_done;
		logic [DATA_W-1:0] rdata;
	} stk_rsp_t;

endpackage

@@ src/tcx_ram.sv @@
// tcx_ram: generic simple dual-port RAM, one write and one registered read port.
// No package dependencies.
module tcx_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/tcx_divider.sv @@
// tcx_divider: 16-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on tcx_pkg (DATA_W).
module tcx_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tcx_pkg::DATA_W-1:0]  dividend,
	input  logic [tcx_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [tcx_pkg::DATA_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(tcx_pkg::DATA_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(tcx_pkg::DATA_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [tcx_pkg::DATA_W-1:0] rem_q;
	logic [tcx_pkg::DATA_W-1:0] quo_q;
	logic [tcx_pkg::DATA_W-1:0] dvs_q;
	logic [tcx_pkg::DATA_W:0]   shifted;
	logic [tcx_pkg::DATA_W:0]   diff;

	assign shifted = {rem_q, quo_q[tcx_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// diff sign bit clear: partial remainder covers the divisor
			if (!diff[tcx_pkg::DATA_W]) begin
				rem_q <= diff[tcx_pkg::DATA_W-1:0];
				quo_q <= {quo_q[tcx_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[tcx_pkg::DATA_W-1:0];
				quo_q <= {quo_q[tcx_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/tcx_stack.sv @@
// tcx_stack: byte stack store split into even and odd banks so a 16-bit
// little-endian word at any byte address is one access; clears itself after reset.
// Depends on tcx_pkg and tcx_ram.
module tcx_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  tcx_pkg::stk_req_t req,
	output tcx_pkg::stk_rsp_t rsp
);

	localparam logic [tcx_pkg::BANK_AW-1:0] CLR_LAST = tcx_pkg::BANK_AW'(tcx_pkg::BANK_DEPTH - 1);

	logic                         clr_busy_q;
	logic [tcx_pkg::BANK_AW-1:0]  clr_cnt_q;
	logic                         lo_odd_q;

	logic [tcx_pkg::ADDR_W-1:0]   a_lo;
	logic [tcx_pkg::ADDR_W-1:0]   a_hi;
	logic [tcx_pkg::ADDR_W-1:0]   even_addr;
	logic [tcx_pkg::ADDR_W-1:0]   odd_addr;
	logic                         lo_odd;

	logic                         bank_we;
	logic [tcx_pkg::BANK_AW-1:0]  even_waddr;
	logic [tcx_pkg::BANK_AW-1:0]  odd_waddr;
	logic [7:0]                   even_wdata;
	logic [7:0]                   odd_wdata;
	logic [7:0]                   even_rdata;
	logic [7:0]                   odd_rdata;

	// low byte at addr, high byte at addr+1, wrapping inside the store
	assign a_lo      = req.addr;
	assign a_hi      = req.addr + 1'b1;
	assign lo_odd    = a_lo[0];
	assign even_addr = lo_odd ? a_hi : a_lo;
	assign odd_addr  = lo_odd ? a_lo : a_hi;

	assign bank_we    = clr_busy_q || req.wr;
	assign even_waddr = clr_busy_q ? clr_cnt_q : even_addr[tcx_pkg::ADDR_W-1:1];
	assign odd_waddr  = clr_busy_q ? clr_cnt_q : odd_addr[tcx_pkg::ADDR_W-1:1];
	assign even_wdata = clr_busy_q ? 8'h00 : (lo_odd ? req.wdata[15:8] : req.wdata[7:0]);
	assign odd_wdata  = clr_busy_q ? 8'h00 : (lo_odd ? req.wdata[7:0] : req.wdata[15:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			lo_odd_q <= lo_odd;
		end
	end

	tcx_ram #(
		.DEPTH(tcx_pkg::BANK_DEPTH),
		.WIDTH(8)
	) u_even (
		.clk  (clk),
		.we   (bank_we),
		.waddr(even_waddr),
		.wdata(even_wdata),
		.raddr(even_addr[tcx_pkg::ADDR_W-1:1]),
		.rdata(even_rdata)
	);

	tcx_ram #(
		.DEPTH(tcx_pkg::BANK_DEPTH),
		.WIDTH(8)
	) u_odd (
		.clk  (clk),
		.we   (bank_we),
		.waddr(odd_waddr),
		.wdata(odd_wdata),
		.raddr(odd_addr[tcx_pkg::ADDR_W-1:1]),
		.rdata(odd_rdata)
	);

	assign rsp.clr_done = !clr_busy_q;
	assign rsp.rdata    = lo_odd_q ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};

endmodule

@@ src/toy_cpu_execute_unit.sv @@
// toy_cpu_execute_unit: top level; instruction sequencer, register file and result register.
// Depends on tcx_pkg, tcx_stack and tcx_divider.
//
//  channel | direction | handshake           | payload
//  in      | into unit | in_valid / in_stall   | command, operand
//  out     | from unit | out_valid / out_stall | reg_a..reg_d, stack_ptr, flag_bits,
//          |           |                       | halted, error_code
//
// One instruction in flight. Accept to result: most commands pass ST_EXEC and ST_DONE, POP
// adds ST_POP (the stack read), DIV adds ST_DIV (the divider iterations plus handoff).
// After reset the stack store is zeroed one bank row per cycle over all MEM_BYTES/2 rows,
// with in_stall high throughout.
// The result register holds a transaction under out_stall while the next one is taken
// and executed; it waits in ST_DONE only if the result register is still occupied.
module toy_cpu_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  command,
	input  logic [15:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] reg_a,
	output logic [15:0] reg_b,
	output logic [15:0] reg_c,
	output logic [15:0] reg_d,
	output logic [15:0] stack_ptr,
	output logic [3:0]  flag_bits,
	output logic        halted,
	output logic [2:0]  error_code
);

	localparam logic [16:0] SP_TOP = 17'(tcx_pkg::MEM_BYTES - 2);

	tcx_pkg::state_t state_q, state_nxt;

	tcx_pkg::cmd_t   cmd_q;
	logic [15:0]     opnd_q;

	logic [15:0]     a_q, b_q, c_q, d_q, sp_q;
	logic [3:0]      flags_q;
	logic            halt_q;
	tcx_pkg::err_t   err_q;
	tcx_pkg::err_t   exec_err;

	logic            out_valid_q;
	logic [15:0]     out_a_q, out_b_q, out_c_q, out_d_q, out_sp_q;
	logic [3:0]      out_flags_q;
	logic            out_halt_q;
	tcx_pkg::err_t   out_err_q;

	logic            bad_reg, sp_low, sp_high;
	logic            push_ok, pop_ok;
	logic            out_free, out_load;
	logic [4:0]      flag_off;
	logic [15:0]     push_val;
	logic [15:0]     sp_dec;
	logic [31:0]     product;

	logic            div_start, div_done;
	logic [15:0]     div_quo;

	tcx_pkg::stk_req_t stk_req;
	tcx_pkg::stk_rsp_t stk_rsp;

	// ---------------- decode ----------------
	assign bad_reg  = |opnd_q[15:2];
	assign sp_low   = sp_q < 16'd2;
	assign sp_high  = {1'b0, sp_q} > SP_TOP;
	assign push_ok  = !halt_q && (cmd_q == tcx_pkg::CMD_PUSH) && !bad_reg && !sp_low;
	assign pop_ok   = !halt_q && (cmd_q == tcx_pkg::CMD_POP) && !bad_reg && !sp_high;
	assign flag_off = cmd_q - tcx_pkg::CMD_STE;
	assign sp_dec   = sp_q - 16'd2;
	assign product  = a_q * b_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (opnd_q[1:0])
			2'd0:    push_val = a_q;
			2'd1:    push_val = b_q;
			2'd2:    push_val = c_q;
			default: push_val = d_q;
		endcase
	end

	always_comb begin
		exec_err = tcx_pkg::ERR_NONE;
		if (!halt_q) begin
			case (cmd_q)
				tcx_pkg::CMD_DIV: begin
					if (b_q == 16'd0) exec_err = tcx_pkg::ERR_DIV0;
				end
				tcx_pkg::CMD_PUSH: begin
					if (bad_reg)     exec_err = tcx_pkg::ERR_BADREG;
					else if (sp_low) exec_err = tcx_pkg::ERR_OVER;
				end
				tcx_pkg::CMD_POP: begin
					if (bad_reg)      exec_err = tcx_pkg::ERR_BADREG;
					else if (sp_high) exec_err = tcx_pkg::ERR_UNDER;
				end
				default: begin
					if (!(cmd_q inside {[tcx_pkg::CMD_NOP:tcx_pkg::CMD_POP]})) begin
						exec_err = tcx_pkg::ERR_ILLEGAL;
					end
				end
			endcase
		end
	end

	// ---------------- state machine ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tcx_pkg::ST_CLEAR: if (stk_rsp.clr_done) state_nxt = tcx_pkg::ST_IDLE;
			tcx_pkg::ST_IDLE:  if (in_valid) state_nxt = tcx_pkg::ST_EXEC;
			tcx_pkg::ST_EXEC: begin
				if (div_start)   state_nxt = tcx_pkg::ST_DIV;
				else if (pop_ok) state_nxt = tcx_pkg::ST_POP;
				else             state_nxt = tcx_pkg::ST_DONE;
			end
			tcx_pkg::ST_DIV:   if (div_done) state_nxt = tcx_pkg::ST_DONE;
			tcx_pkg::ST_POP:   state_nxt = tcx_pkg::ST_DONE;
			tcx_pkg::ST_DONE:  if (out_free) state_nxt = tcx_pkg::ST_IDLE;
			default:           state_nxt = tcx_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != tcx_pkg::ST_IDLE);
		div_start     = 1'b0;
		out_load      = 1'b0;
		stk_req.wr    = 1'b0;
		stk_req.rd    = 1'b0;
		stk_req.addr  = sp_q[tcx_pkg::ADDR_W-1:0];
		stk_req.wdata = push_val;
		case (state_q)
			tcx_pkg::ST_EXEC: begin
				div_start  = !halt_q && (cmd_q == tcx_pkg::CMD_DIV) && (b_q != 16'd0);
				stk_req.wr = push_ok;
				stk_req.rd = pop_ok;
				// push stores below SP, pop reads at SP
				if (push_ok) stk_req.addr = sp_dec[tcx_pkg::ADDR_W-1:0];
			end
			tcx_pkg::ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcx_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------- architectural state ----------------
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q  <= tcx_pkg::cmd_t'(command);
			opnd_q <= operand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			sp_q    <= '0;
			flags_q <= '0;
			halt_q  <= 1'b0;
			err_q   <= tcx_pkg::ERR_NONE;
		end else begin
			case (state_q)
				tcx_pkg::ST_EXEC: begin
					err_q <= exec_err;
					if (!halt_q) begin
						case (cmd_q)
							tcx_pkg::CMD_HLT:  halt_q <= 1'b1;
							tcx_pkg::CMD_MOVA: a_q <= opnd_q;
							tcx_pkg::CMD_MOVB: b_q <= opnd_q;
							tcx_pkg::CMD_MOVC: c_q <= opnd_q;
							tcx_pkg::CMD_MOVD: d_q <= opnd_q;
							tcx_pkg::CMD_MOVS: sp_q <= opnd_q;
							tcx_pkg::CMD_ADD:  a_q <= a_q + b_q;
							tcx_pkg::CMD_SUB:  a_q <= a_q - b_q;
							tcx_pkg::CMD_MUL:  a_q <= product[15:0];
							tcx_pkg::CMD_PUSH: if (push_ok) sp_q <= sp_dec;
							default: begin
								// even offsets set a flag, odd offsets clear it
								if (cmd_q inside {[tcx_pkg::CMD_STE:tcx_pkg::CMD_CLL]}) begin
									flags_q[flag_off[2:1]] <= !flag_off[0];
								end
							end
						endcase
					end
				end
				tcx_pkg::ST_DIV: if (div_done) a_q <= div_quo;
				tcx_pkg::ST_POP: begin
					case (opnd_q[1:0])
						2'd0:    a_q <= stk_rsp.rdata;
						2'd1:    b_q <= stk_rsp.rdata;
						2'd2:    c_q <= stk_rsp.rdata;
						default: d_q <= stk_rsp.rdata;
					endcase
					sp_q <= sp_q + 16'd2;
				end
				default: ;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_a_q     <= a_q;
			out_b_q     <= b_q;
			out_c_q     <= c_q;
			out_d_q     <= d_q;
			out_sp_q    <= sp_q;
			out_flags_q <= flags_q;
			out_halt_q  <= halt_q;
			out_err_q   <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_a      = out_a_q;
	assign reg_b      = out_b_q;
	assign reg_c      = out_c_q;
	assign reg_d      = out_d_q;
	assign stack_ptr  = out_sp_q;
	assign flag_bits  = out_flags_q;
	assign halted     = out_halt_q;
	assign error_code = out_err_q;

	// ---------------- units ----------------
	tcx_stack u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (stk_req),
		.rsp   (stk_rsp)
	);

	tcx_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(a_q),
		.divisor (b_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// ---------------- assertions ----------------
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt latch dropped");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == tcx_pkg::ST_DIV)
		else $error("divider finished outside divide state");

	a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_req.wr || stk_req.rd) |-> stk_rsp.clr_done)
		else $error("stack access during clearing pass");

	a_err_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_err_q <= tcx_pkg::ERR_ILLEGAL)
		else $error("result carries undefined error code");

endmodule

@@ sim/testbench.sv @@
// testbench: self-checking bench for toy_cpu_execute_unit. Directed table first, then random
// instruction streams under changing idle/stall patterns, checked against an in-bench model.
// Depends on tcx_pkg and the RTL under src.
module testbench;

	localparam int RAND_ITEMS     = 1810;
	localparam int WATCHDOG_LIMIT = 150000;	// covers the stack clear after reset
	localparam int DRAIN_CYCLES   = 40;
	localparam logic [4:0] CMD_ILL_LO = 5'd21;
	localparam logic [4:0] CMD_ILL_HI = 5'd31;
	localparam int DIR_ROWS = 31;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic [15:0] sp;
		logic [3:0]  flags;
		logic        halted;
		logic [2:0]  err;
	} cpu_view_t;

	typedef struct {
		logic [4:0]      cmd;
		logic [15:0]     opnd;
		bit              typed;
		logic [15:0]     a;
		logic [15:0]     sp;
		tcx_pkg::err_t   err;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [4:0]  command = '0;
	logic [15:0] operand = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [15:0] reg_a, reg_b, reg_c, reg_d, stack_ptr;
	logic [3:0]  flag_bits;
	logic        halted;
	logic [2:0]  error_code;

	// machine state as the bench sees it
	logic [15:0] arch_a, arch_b, arch_c, arch_d, arch_sp;
	logic [3:0]  arch_flags;
	logic        arch_halt;
	bit   [7:0]  stack_mem [0:tcx_pkg::MEM_BYTES-1];

	cpu_view_t pending_views[$];
	int        errors_seen = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	dir_row_t  dir_rows [0:DIR_ROWS-1];

	toy_cpu_execute_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.operand    (operand),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_a      (reg_a),
		.reg_b      (reg_b),
		.reg_c      (reg_c),
		.reg_d      (reg_d),
		.stack_ptr  (stack_ptr),
		.flag_bits  (flag_bits),
		.halted     (halted),
		.error_code (error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] read_reg(input logic [1:0] idx);
		case (idx)
			2'd0: return arch_a;
			2'd1: return arch_b;
			2'd2: return arch_c;
			default: return arch_d;
		endcase
	endfunction

	function automatic void write_reg(input logic [1:0] idx, input logic [15:0] val);
		case (idx)
			2'd0: arch_a = val;
			2'd1: arch_b = val;
			2'd2: arch_c = val;
			default: arch_d = val;
		endcase
	endfunction

	// Runs one instruction on the bench state and returns the state the unit should show.
	function automatic cpu_view_t execute_insn(input logic [4:0] c, input logic [15:0] op);
		cpu_view_t     v;
		tcx_pkg::err_t e;
		logic [15:0]   w;
		int unsigned   k;
		e = tcx_pkg::ERR_NONE;
		if (!arch_halt) begin
			case (c)
				tcx_pkg::CMD_NOP: ;
				tcx_pkg::CMD_HLT: arch_halt = 1'b1;
				tcx_pkg::CMD_MOVA: arch_a = op;
				tcx_pkg::CMD_MOVB: arch_b = op;
				tcx_pkg::CMD_MOVC: arch_c = op;
				tcx_pkg::CMD_MOVD: arch_d = op;
				tcx_pkg::CMD_MOVS: arch_sp = op;
				tcx_pkg::CMD_ADD: arch_a = arch_a + arch_b;
				tcx_pkg::CMD_SUB: arch_a = arch_a - arch_b;
				tcx_pkg::CMD_MUL: arch_a = arch_a * arch_b;
				tcx_pkg::CMD_DIV: begin
					if (arch_b == 16'd0)
						e = tcx_pkg::ERR_DIV0;
					else
						arch_a = arch_a / arch_b;
				end
				tcx_pkg::CMD_STE, tcx_pkg::CMD_CLE, tcx_pkg::CMD_STG, tcx_pkg::CMD_CLG,
				tcx_pkg::CMD_STH, tcx_pkg::CMD_CLH, tcx_pkg::CMD_STL, tcx_pkg::CMD_CLL: begin
					k = c - tcx_pkg::CMD_STE;
					if (k % 2 == 0)
						arch_flags = arch_flags | (4'b0001 << (k / 2));
					else
						arch_flags = arch_flags & ~(4'b0001 << (k / 2));
				end
				tcx_pkg::CMD_PUSH: begin
					if (op > 16'd3) begin
						e = tcx_pkg::ERR_BADREG;
					end else if (arch_sp < 16'd2) begin
						e = tcx_pkg::ERR_OVER;
					end else begin
						w = read_reg(op[1:0]);
						arch_sp = arch_sp - 16'd2;
						stack_mem[int'(arch_sp) % tcx_pkg::MEM_BYTES] = w[7:0];
						stack_mem[(int'(arch_sp) + 1) % tcx_pkg::MEM_BYTES] = w[15:8];
					end
				end
				tcx_pkg::CMD_POP: begin
					if (op > 16'd3) begin
						e = tcx_pkg::ERR_BADREG;
					end else if (int'(arch_sp) > tcx_pkg::MEM_BYTES - 2) begin
						e = tcx_pkg::ERR_UNDER;
					end else begin
						w = {stack_mem[(int'(arch_sp) + 1) % tcx_pkg::MEM_BYTES],
							stack_mem[int'(arch_sp) % tcx_pkg::MEM_BYTES]};
						write_reg(op[1:0], w);
						arch_sp = arch_sp + 16'd2;
					end
				end
				default: e = tcx_pkg::ERR_ILLEGAL;
			endcase
		end
		v.a = arch_a;
		v.b = arch_b;
		v.c = arch_c;
		v.d = arch_d;
		v.sp = arch_sp;
		v.flags = arch_flags;
		v.halted = arch_halt;
		v.err = e;
		return v;
	endfunction

	function automatic logic [15:0] edgy_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h0001;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] stack_index();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
	endfunction

	// Push/pop traffic around a usable SP, with register loads, arithmetic, flags and noise mixed in.
	task automatic pick_insn(output logic [4:0] c, output logic [15:0] op);
		int r;
		r = $urandom_range(0, 99);
		op = 16'($urandom());
		if (r < 16) begin
			c = tcx_pkg::CMD_MOVA + 5'($urandom_range(0, 3));
			op = edgy_word();
		end else if (r < 21) begin
			c = tcx_pkg::CMD_MOVS;
			case ($urandom_range(0, 5))
				0: op = 16'($urandom_range(0, 3));
				1: op = 16'($urandom_range(16'hfffc, 16'hffff));
				default: op = 16'($urandom_range(256, 65535));
			endcase
		end else if (r < 40) begin
			c = tcx_pkg::CMD_ADD + 5'($urandom_range(0, 3));
		end else if (r < 48) begin
			c = tcx_pkg::CMD_STE + 5'($urandom_range(0, 7));
		end else if (r < 66) begin
			c = tcx_pkg::CMD_PUSH;
			op = stack_index();
		end else if (r < 84) begin
			c = tcx_pkg::CMD_POP;
			op = stack_index();
		end else if (r < 89) begin
			c = tcx_pkg::CMD_NOP;
		end else if (r < 94) begin
			c = 5'($urandom_range(CMD_ILL_LO, CMD_ILL_HI));
		end else begin
			// divisor reloads, zero now and then
			c = tcx_pkg::CMD_MOVB;
			op = ($urandom_range(0, 3) == 0) ? 16'd0 : edgy_word();
		end
	endtask

	task automatic issue_insn(input logic [4:0] c, input logic [15:0] op, input bit typed,
			input cpu_view_t typed_view);
		cpu_view_t v;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		operand <= op;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		v = execute_insn(c, op);
		pending_views.push_back(typed ? typed_view : v);
	endtask

	task automatic cmp_field(input string fname, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
			errors_seen++;
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

	always @(posedge clk) begin
		cpu_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				errors_seen++;
			end else begin
				want = pending_views.pop_front();
				cmp_field("reg_a", want.a, reg_a);
				cmp_field("reg_b", want.b, reg_b);
				cmp_field("reg_c", want.c, reg_c);
				cmp_field("reg_d", want.d, reg_d);
				cmp_field("stack_ptr", want.sp, stack_ptr);
				cmp_field("flag_bits", 16'(want.flags), 16'(flag_bits));
				cmp_field("halted", 16'(want.halted), 16'(halted));
				cmp_field("error_code", 16'(want.err), 16'(error_code));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		cpu_view_t   tv;
		logic [4:0]  c;
		logic [15:0] op;
		int          ph;
		arch_a = '0;
		arch_b = '0;
		arch_c = '0;
		arch_d = '0;
		arch_sp = '0;
		arch_flags = '0;
		arch_halt = 1'b0;
		// typed rows run while BX, CX, DX and the flags are still zero
		dir_rows = '{
			'{tcx_pkg::CMD_NOP,  16'hffff, 1'b1, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_DIV,  16'h0000, 1'b1, 16'h0000, 16'h0000, tcx_pkg::ERR_DIV0},
			'{tcx_pkg::CMD_PUSH, 16'h0000, 1'b1, 16'h0000, 16'h0000, tcx_pkg::ERR_OVER},
			'{tcx_pkg::CMD_POP,  16'h0003, 1'b1, 16'h0000, 16'h0002, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_PUSH, 16'h0004, 1'b1, 16'h0000, 16'h0002, tcx_pkg::ERR_BADREG},
			'{tcx_pkg::CMD_POP,  16'hffff, 1'b1, 16'h0000, 16'h0002, tcx_pkg::ERR_BADREG},
			'{CMD_ILL_LO,        16'haaaa, 1'b1, 16'h0000, 16'h0002, tcx_pkg::ERR_ILLEGAL},
			'{CMD_ILL_HI,        16'h5555, 1'b1, 16'h0000, 16'h0002, tcx_pkg::ERR_ILLEGAL},
			'{tcx_pkg::CMD_MOVA, 16'hffff, 1'b1, 16'hffff, 16'h0002, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MOVS, 16'hffff, 1'b1, 16'hffff, 16'hffff, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_POP,  16'h0000, 1'b1, 16'hffff, 16'hffff, tcx_pkg::ERR_UNDER},
			'{tcx_pkg::CMD_MOVB, 16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_ADD,  16'h1234, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MUL,  16'h0000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_SUB,  16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MOVB, 16'h0003, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_DIV,  16'h8000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_STE,  16'h0000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_STG,  16'h0000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_STH,  16'h0000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_STL,  16'h0000, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_CLE,  16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_CLG,  16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_CLH,  16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_CLL,  16'hffff, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MOVC, 16'h1234, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MOVD, 16'habcd, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_MOVS, 16'h0004, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_PUSH, 16'h0002, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_PUSH, 16'h0003, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE},
			'{tcx_pkg::CMD_PUSH, 16'h0001, 1'b0, 16'h0000, 16'h0000, tcx_pkg::ERR_NONE}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			tv = '0;
			tv.a = dir_rows[i].a;
			tv.sp = dir_rows[i].sp;
			tv.err = dir_rows[i].err;
			issue_insn(dir_rows[i].cmd, dir_rows[i].opnd, dir_rows[i].typed, tv);
		end
		issue_insn(tcx_pkg::CMD_POP, 16'h0000, 1'b0, '0);

		// halt is never drawn here; it would freeze the rest of the run
		for (int i = 0; i < RAND_ITEMS; i++) begin
			ph = i * 4 / RAND_ITEMS;
			src_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 17 : 0;
			sink_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 17 : 0;
			pick_insn(c, op);
			issue_insn(c, op, 1'b0, '0);
		end

		// halt last; everything after it must leave the state alone
		issue_insn(tcx_pkg::CMD_HLT, 16'($urandom()), 1'b0, '0);
		for (int i = 0; i < 6; i++)
			issue_insn(5'($urandom_range(0, 31)), 16'($urandom()), 1'b0, '0);
		issue_insn(CMD_ILL_HI, 16'hffff, 1'b0, '0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors_seen == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
